>>> hdl/psh_pkg.sv
// ----------------------------------------------------------------------------
// psh_pkg
// Shared types and constants of the point cyclic shuffle block.
// ----------------------------------------------------------------------------
package psh_pkg;

  // Width of one coordinate and of one random word.
  localparam int unsigned WORD_W = 32;

  // Width of a full point with all three coordinates.
  localparam int unsigned PT_FULL_W = 3 * WORD_W;

  // Controller states.
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SH_RND,
    ST_SH_MUL,
    ST_SH_RD,
    ST_SH_WA,
    ST_SH_WB,
    ST_EM_RD,
    ST_EM_LD
  } psh_state_t;

endpackage

>>> hdl/psh_ram_1r.sv
// ----------------------------------------------------------------------------
// psh_ram_1r
// Synchronous memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module psh_ram_1r #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/psh_ram_2r.sv
// ----------------------------------------------------------------------------
// psh_ram_2r
// Synchronous memory with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module psh_ram_2r #(
  parameter int unsigned WIDTH = 96,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Both read ports, registered.
  always_ff @(posedge clk) begin
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

>>> hdl/point_cyclic_shuffle.sv
// ----------------------------------------------------------------------------
// point_cyclic_shuffle
// Loads a set of points with one random word each, permutes them in place by
// the cyclic shuffle and emits them in their new order.
//
//   channel | direction | words                   | marker
//   --------+-----------+-------------------------+------------------
//   in_     | input     | one point + random word | in_last_point
//   out_    | output    | one permuted point      | out_last
//
// Loading accepts one word per cycle. After the last word, the shuffle
// fetches and scales the first random word, then per swap reads both points,
// writes one and writes the other, all on the single write port of the point
// memory. Emission reads each word from memory, then loads the output register,
// and stops while out_ready is low. No new word is accepted between the last
// word of a set and the loading of its final result into the output register.
// Reset is synchronous and clears only control state; the memories are not
// cleared, as only entries written in the current set are ever read.
// ----------------------------------------------------------------------------
module point_cyclic_shuffle
  import psh_pkg::*;
#(
  parameter int unsigned MAX_POINTS = 64,
  parameter int unsigned DIMENSIONS = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_coord_a,
  input  logic [31:0] in_coord_b,
  input  logic [31:0] in_coord_c,
  input  logic [31:0] in_random_word,
  input  logic        in_last_point,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_coord_a,
  output logic [31:0] out_coord_b,
  output logic [31:0] out_coord_c,
  output logic        out_last,
  output logic        out_overflow_seen
);

  localparam int unsigned AW = $clog2(MAX_POINTS);
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam int unsigned PW = WORD_W * DIMENSIONS;
  localparam int unsigned MW = WORD_W + CW;

  psh_state_t state_r, state_nxt;

  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [CW-1:0]        n_r, n_nxt;
  logic [AW-1:0]        idx_r, idx_nxt;
  logic [CW-1:0]        span_r, span_nxt;
  logic [MW-1:0]        prod_r, prod_nxt;
  logic [AW-1:0]        j_r, j_nxt;
  logic [PW-1:0]        pi_r, pi_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [PT_FULL_W-1:0] out_pt_r, out_pt_nxt;
  logic                 out_last_r, out_last_nxt;
  logic                 out_ovf_r, out_ovf_nxt;

  logic                 pt_we;
  logic [AW-1:0]        pt_waddr;
  logic [PW-1:0]        pt_wdata;
  logic [AW-1:0]        pt_raddr0, pt_raddr1;
  logic [PW-1:0]        pt_rdata0, pt_rdata1;
  logic                 rnd_we;
  logic [AW-1:0]        rnd_raddr;
  logic [WORD_W-1:0]    rnd_rdata;

  logic                 in_fire, out_fire, room;
  logic [CW-1:0]        n_load, j_sum, j_sel, span_dec;
  logic [PT_FULL_W-1:0] in_pt_full;

  // Point and random word storage.
  psh_ram_2r #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_pt_mem (
    .clk    (clk),
    .we     (pt_we),
    .waddr  (pt_waddr),
    .wdata  (pt_wdata),
    .raddr0 (pt_raddr0),
    .raddr1 (pt_raddr1),
    .rdata0 (pt_rdata0),
    .rdata1 (pt_rdata1)
  );

  psh_ram_1r #(.WIDTH(WORD_W), .DEPTH(MAX_POINTS)) u_rnd_mem (
    .clk   (clk),
    .we    (rnd_we),
    .waddr (cnt_r[AW-1:0]),
    .wdata (in_random_word),
    .raddr (rnd_raddr),
    .rdata (rnd_rdata)
  );

  assign in_ready   = (state_r == ST_LOAD);
  assign in_fire    = in_valid && in_ready;
  assign out_fire   = out_valid_r && out_ready;
  assign room       = (cnt_r < CW'(MAX_POINTS));
  assign in_pt_full = {in_coord_c, in_coord_b, in_coord_a};
  assign n_load     = room ? (cnt_r + CW'(1)) : cnt_r;
  assign span_dec   = span_r - CW'(1);

  // Swap partner: i+1 plus the scaled random offset, kept below n.
  assign j_sum = CW'(idx_r) + CW'(1) + prod_r[MW-1:WORD_W];
  assign j_sel = (j_sum >= n_r) ? (n_r - CW'(1)) : j_sum;

  // State register and datapath registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    idx_r      <= idx_nxt;
    span_r     <= span_nxt;
    prod_r     <= prod_nxt;
    j_r        <= j_nxt;
    pi_r       <= pi_nxt;
    out_pt_r   <= out_pt_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  // Next state, memory control and output register loading.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    n_nxt         = n_r;
    idx_nxt       = idx_r;
    span_nxt      = span_r;
    prod_nxt      = prod_r;
    j_nxt         = j_r;
    pi_nxt        = pi_r;
    out_pt_nxt    = out_pt_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    out_valid_nxt = out_valid_r && !out_ready;
    pt_we         = 1'b0;
    pt_waddr      = cnt_r[AW-1:0];
    pt_wdata      = in_pt_full[PW-1:0];
    pt_raddr0     = idx_r;
    pt_raddr1     = j_r;
    rnd_we        = 1'b0;
    rnd_raddr     = idx_r;

    case (state_r)
      ST_LOAD: begin
        if (in_fire) begin
          if (room) begin
            pt_we   = 1'b1;
            rnd_we  = 1'b1;
            cnt_nxt = cnt_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last_point) begin
            n_nxt    = n_load;
            idx_nxt  = '0;
            span_nxt = n_load - CW'(1);
            if (n_load == CW'(1)) begin
              state_nxt = ST_EM_RD;
            end else begin
              state_nxt = ST_SH_RND;
            end
          end
        end
      end

      // Fetch the random word of the first position.
      ST_SH_RND: begin
        rnd_raddr = idx_r;
        state_nxt = ST_SH_MUL;
      end

      ST_SH_MUL: begin
        prod_nxt  = MW'(rnd_rdata) * MW'(span_r);
        state_nxt = ST_SH_RD;
      end

      // Read point i and its partner j.
      ST_SH_RD: begin
        pt_raddr0 = idx_r;
        pt_raddr1 = j_sel[AW-1:0];
        j_nxt     = j_sel[AW-1:0];
        state_nxt = ST_SH_WA;
      end

      // Write point j into slot i; fetch the next random word meanwhile.
      ST_SH_WA: begin
        pt_we     = 1'b1;
        pt_waddr  = idx_r;
        pt_wdata  = pt_rdata1;
        pi_nxt    = pt_rdata0;
        rnd_raddr = idx_r + AW'(1);
        state_nxt = ST_SH_WB;
      end

      // Write point i into slot j and scale the next random word.
      ST_SH_WB: begin
        pt_we    = 1'b1;
        pt_waddr = j_r;
        pt_wdata = pi_r;
        span_nxt = span_dec;
        prod_nxt = MW'(rnd_rdata) * MW'(span_dec);
        if (span_r == CW'(1)) begin
          idx_nxt   = '0;
          state_nxt = ST_EM_RD;
        end else begin
          idx_nxt   = idx_r + AW'(1);
          state_nxt = ST_SH_RD;
        end
      end

      // Read the next point once the output register frees up.
      ST_EM_RD: begin
        pt_raddr0 = idx_r;
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_EM_LD;
        end
      end

      ST_EM_LD: begin
        out_valid_nxt = 1'b1;
        out_pt_nxt    = PT_FULL_W'(pt_rdata0);
        out_last_nxt  = (CW'(idx_r) + CW'(1) == n_r);
        out_ovf_nxt   = ovf_r;
        idx_nxt       = idx_r + AW'(1);
        if (CW'(idx_r) + CW'(1) == n_r) begin
          cnt_nxt   = '0;
          ovf_nxt   = 1'b0;
          state_nxt = ST_LOAD;
        end else begin
          state_nxt = ST_EM_RD;
        end
      end

      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  // Output ports.
  assign out_valid         = out_valid_r;
  assign out_coord_a       = out_pt_r[WORD_W-1:0];
  assign out_coord_b       = out_pt_r[2*WORD_W-1:WORD_W];
  assign out_coord_c       = out_pt_r[3*WORD_W-1:2*WORD_W];
  assign out_last          = out_last_r;
  assign out_overflow_seen = out_ovf_r;

`ifndef SYNTHESIS
  // The fill count never passes the capacity.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_POINTS))
    else $error("point count beyond capacity");

  // A swap partner always lies above i and inside the set.
  a_j_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SH_RD) |-> (j_sel > CW'(idx_r)) && (j_sel < n_r))
    else $error("swap partner out of range");

  // After the final word of a set is loaded, the set state is cleared.
  a_set_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EM_LD) && (CW'(idx_r) + CW'(1) == n_r)
      |=> (cnt_r == '0) && !ovf_r && (state_r == ST_LOAD))
    else $error("set state not cleared after emission");

  // The output register is loaded only from the emit load step.
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_EM_LD))
    else $error("output word loaded outside emission");
`endif

endmodule

>>> verif/tb_point_cyclic_shuffle.sv
// ----------------------------------------------------------------------------
// tb_point_cyclic_shuffle
// Self-checking testbench of the point cyclic shuffle block. A directed table
// covers single-point sets, extreme coordinates and the edge values of the
// random word. Random point sets of mixed sizes follow, including full and
// overflowing sets. Both channels idle in random bursts. Every emitted word is
// compared field by field with a typed row or the testbench shuffle predictor.
// ----------------------------------------------------------------------------
module tb_point_cyclic_shuffle
  import psh_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_PTS      = 64;
  localparam int unsigned DIMS         = 3;
  localparam int          ITEM_TARGET  = 400;
  localparam int          CALM_ITEMS   = 60;
  localparam int          CYCLE_LIMIT  = 300000;
  localparam int          DRAIN_CYCLES = 20;
  localparam int          ROW_COUNT    = 17;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
  } point_t;

  // One emitted point as the block should present it.
  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    logic  last;
    logic  ovf;
  } emitted_t;

  // One directed word; rows with a typed expectation are whole one-point sets.
  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t rnd;
    logic  last;
    logic  typed;
    word_t ea;
    word_t eb;
    word_t ec;
  } row_t;

  localparam row_t DIRECTED_ROWS [ROW_COUNT] = '{
    // One-point sets: the point comes straight back with out_last set.
    '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1,
      32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1,
      32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
    '{32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_1234, 1'b1, 1'b1,
      32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF},
    // Two points, lowest then highest random word.
    '{32'h1111_1111, 32'h2222_2222, 32'h3333_3333, 32'h0000_0000, 1'b0, 1'b0,
      '0, '0, '0},
    '{32'h4444_4444, 32'h5555_5555, 32'h6666_6666, 32'hFFFF_FFFF, 1'b1, 1'b0,
      '0, '0, '0},
    // Two points, highest then lowest random word.
    '{32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFF, 1'b0, 1'b0,
      '0, '0, '0},
    '{32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0000, 1'b1, 1'b0,
      '0, '0, '0},
    // Three points: the first swap takes the nearest partner.
    '{32'h0000_00A1, 32'h0000_00A2, 32'h0000_00A3, 32'h0000_0000, 1'b0, 1'b0,
      '0, '0, '0},
    '{32'h0000_00B1, 32'h0000_00B2, 32'h0000_00B3, 32'hFFFF_FFFF, 1'b0, 1'b0,
      '0, '0, '0},
    '{32'h0000_00C1, 32'h0000_00C2, 32'h0000_00C3, 32'h1357_9BDF, 1'b1, 1'b0,
      '0, '0, '0},
    // Three points: the first swap takes the farthest partner.
    '{32'hF000_0001, 32'hF000_0002, 32'hF000_0003, 32'h8000_0000, 1'b0, 1'b0,
      '0, '0, '0},
    '{32'hE000_0001, 32'hE000_0002, 32'hE000_0003, 32'h7FFF_FFFF, 1'b0, 1'b0,
      '0, '0, '0},
    '{32'hD000_0001, 32'hD000_0002, 32'hD000_0003, 32'hFFFF_FFFF, 1'b1, 1'b0,
      '0, '0, '0},
    // Four points with split random words.
    '{32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h00FF_00FF, 32'h5555_5555, 1'b0, 1'b0,
      '0, '0, '0},
    '{32'hFF00_FF00, 32'h0000_FFFF, 32'hFFFF_0000, 32'hAAAA_AAAA, 1'b0, 1'b0,
      '0, '0, '0},
    '{32'h1234_5678, 32'h9ABC_DEF0, 32'h0FED_CBA9, 32'hC000_0000, 1'b0, 1'b0,
      '0, '0, '0},
    '{32'h8765_4321, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b0,
      '0, '0, '0}
  };

  logic  clk            = 1'b0;
  logic  rst_n          = 1'b0;
  logic  in_valid       = 1'b0;
  logic  in_ready;
  word_t in_coord_a     = '0;
  word_t in_coord_b     = '0;
  word_t in_coord_c     = '0;
  word_t in_random_word = '0;
  logic  in_last_point  = 1'b0;
  logic  out_valid;
  logic  out_ready      = 1'b0;
  word_t out_coord_a;
  word_t out_coord_b;
  word_t out_coord_c;
  logic  out_last;
  logic  out_overflow_seen;

  // Points and random words of the set being loaded, and the emission queue.
  point_t   set_points[$];
  word_t    set_rands[$];
  logic     set_dropped = 1'b0;
  emitted_t emitted_words[$];

  int words_sent = 0;
  int errors     = 0;
  int cycles     = 0;
  bit calm       = 1'b0;

  point_cyclic_shuffle #(
    .MAX_POINTS(MAX_PTS),
    .DIMENSIONS(DIMS)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_coord_a       (in_coord_a),
    .in_coord_b       (in_coord_b),
    .in_coord_c       (in_coord_c),
    .in_random_word   (in_random_word),
    .in_last_point    (in_last_point),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_coord_a      (out_coord_a),
    .out_coord_b      (out_coord_b),
    .out_coord_c      (out_coord_c),
    .out_last         (out_last),
    .out_overflow_seen(out_overflow_seen)
  );

  // Clock with a 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shuffle predictor: stores the point while the set has room, and on the last
  // word of a set runs the cyclic shuffle and queues the whole set in its new order.
  function automatic void shuffle_point(point_t p, word_t rnd, logic last);
    int          n;
    int unsigned j;
    logic [63:0] prod;
    point_t      tmp;
    emitted_t    w;
    if (DIMS < 2) p.b = '0;
    if (DIMS < 3) p.c = '0;
    if (set_points.size() < MAX_PTS) begin
      set_points.push_back(p);
      set_rands.push_back(rnd);
    end else begin
      set_dropped = 1'b1;
    end
    if (!last) return;
    n = set_points.size();
    for (int i = 0; i + 1 < n; i++) begin
      prod = {32'b0, set_rands[i]} * 64'(n - 1 - i);
      j = i + 1 + prod[63:32];
      if (j >= n) j = n - 1;
      tmp           = set_points[i];
      set_points[i] = set_points[j];
      set_points[j] = tmp;
    end
    for (int i = 0; i < n; i++) begin
      w.a    = set_points[i].a;
      w.b    = set_points[i].b;
      w.c    = set_points[i].c;
      w.last = (i == n - 1);
      w.ovf  = set_dropped;
      emitted_words.push_back(w);
    end
    set_points.delete();
    set_rands.delete();
    set_dropped = 1'b0;
  endfunction

  // Offers one word, with an optional idle burst in front, and waits for it.
  task automatic send_point(input point_t p, input word_t rnd, input logic last);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_coord_a     <= p.a;
    in_coord_b     <= p.b;
    in_coord_c     <= p.c;
    in_random_word <= rnd;
    in_last_point  <= last;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    calm = (words_sent >= ITEM_TARGET - CALM_ITEMS);
  endtask

  // Random word with extra weight on the two ends of its range.
  function automatic word_t pick_random_word();
    int unsigned sel;
    sel = $urandom_range(0, 7);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return $urandom;
  endfunction

  function automatic void check_field(string name, word_t exp_val, word_t act_val);
    if (exp_val !== act_val) begin
      $error("%s mismatch: expected %h, actual %h", name, exp_val, act_val);
      errors++;
    end
  endfunction

  // Output side: stalls in random bursts until the run calms down.
  initial begin
    forever begin
      if (!calm) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  // Compare each accepted output word with the oldest expectation.
  always @(posedge clk) begin
    emitted_t w;
    if (rst_n && out_valid && out_ready) begin
      if (emitted_words.size() == 0) begin
        $error("output word with no expectation: a=%h b=%h c=%h",
               out_coord_a, out_coord_b, out_coord_c);
        errors++;
      end else begin
        w = emitted_words.pop_front();
        check_field("out_coord_a", w.a, out_coord_a);
        check_field("out_coord_b", w.b, out_coord_b);
        check_field("out_coord_c", w.c, out_coord_c);
        check_field("out_last", word_t'(w.last), word_t'(out_last));
        check_field("out_overflow_seen", word_t'(w.ovf), word_t'(out_overflow_seen));
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("point_cyclic_shuffle regression: fail");
      $finish;
    end
  end

  // Main sequence: reset, directed table, random sets, drain.
  initial begin
    point_t      p;
    emitted_t    w;
    int          set_no;
    int          set_size;
    int unsigned sel;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table; typed rows carry their own expectation.
    for (int r = 0; r < ROW_COUNT; r++) begin
      p = '{DIRECTED_ROWS[r].a, DIRECTED_ROWS[r].b, DIRECTED_ROWS[r].c};
      send_point(p, DIRECTED_ROWS[r].rnd, DIRECTED_ROWS[r].last);
      if (DIRECTED_ROWS[r].typed) begin
        w = '{DIRECTED_ROWS[r].ea, DIRECTED_ROWS[r].eb, DIRECTED_ROWS[r].ec, 1'b1, 1'b0};
        emitted_words.push_back(w);
      end else begin
        shuffle_point(p, DIRECTED_ROWS[r].rnd, DIRECTED_ROWS[r].last);
      end
    end

    // Random sets: a full set and an overflowing one first, then mostly small
    // sets with the odd large, full or overflowing one.
    set_no = 0;
    while (words_sent < ITEM_TARGET) begin
      if (set_no == 0) begin
        set_size = MAX_PTS;
      end else if (set_no == 1) begin
        set_size = MAX_PTS + 3;
      end else begin
        sel = $urandom_range(0, 39);
        if (sel < 30) set_size = $urandom_range(1, 8);
        else if (sel < 37) set_size = $urandom_range(9, 40);
        else if (sel < 38) set_size = MAX_PTS;
        else set_size = $urandom_range(MAX_PTS + 1, MAX_PTS + 4);
      end
      for (int k = 0; k < set_size; k++) begin
        p = '{$urandom, $urandom, $urandom};
        w.a = pick_random_word();
        send_point(p, w.a, k == set_size - 1);
        shuffle_point(p, w.a, k == set_size - 1);
      end
      set_no++;
    end
    in_valid <= 1'b0;

    // Drain the output side, then allow for a late stray word.
    while (emitted_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("point_cyclic_shuffle regression: pass");
    end else begin
      $display("point_cyclic_shuffle regression: fail");
    end
    $finish;
  end

endmodule
